// File: src/dac_pkg.sv
package dac_pkg;

	// Widths of the payload fields and configuration registers.
	localparam int unsigned UID_W     = 32;
	localparam int unsigned NOW_W     = 32;
	localparam int unsigned ANGLE_W   = 8;
	localparam int unsigned BEEPS_W   = 4;
	localparam int unsigned MS16_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	// Default width of the stored time marks.
	localparam int unsigned TIME_BITS_DEF = 32;

	// Timing of the lamp and buzzer patterns in milliseconds.
	localparam int unsigned RED_BLINK_OFF_MS = 2000;
	localparam int unsigned RED_BLINK_END_MS = 2100;
	localparam int unsigned DENY_MS          = 2000;
	localparam int unsigned BEEP_ON_MS       = 200;
	localparam int unsigned BEEP_PERIOD_MS   = 400;
	localparam int unsigned ALARM_ON_MS      = 1000;
	localparam int unsigned ALARM_PERIOD_MS  = 1500;
	localparam int unsigned CLOSE_MARK_BACK  = 3000;

	// Servo step per control pass and the saturation points of the ramp.
	localparam logic [ANGLE_W-1:0] ANGLE_STEP    = 8'd2;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd255;
	localparam logic [ANGLE_W-1:0] ANGLE_RISE_LIM = 8'd253;

	// Register reset values.
	localparam logic [UID_W-1:0]   ACCEPTED_UID_RST     = 32'h778A_6634;
	localparam logic [ANGLE_W-1:0] OPEN_ANGLE_RST       = 8'd150;
	localparam logic [ANGLE_W-1:0] CLOSED_ANGLE_RST     = 8'd10;
	localparam logic [BEEPS_W-1:0] BEEP_COUNT_RST       = 4'd2;
	localparam logic [MS16_W-1:0]  OPEN_HOLD_MS_RST     = 16'd4000;
	localparam logic [MS16_W-1:0]  ALARM_HOLDOFF_MS_RST = 16'd5000;
	localparam logic [ANGLE_W-1:0] ANGLE_RST            = 8'd10;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEPTED_UID     = 3'd0,
		CFG_OPEN_ANGLE       = 3'd1,
		CFG_CLOSED_ANGLE     = 3'd2,
		CFG_BEEP_COUNT       = 3'd3,
		CFG_OPEN_HOLD_MS     = 3'd4,
		CFG_ALARM_HOLDOFF_MS = 3'd5
	} cfg_idx_t;

	// Buzzer pattern in progress.
	typedef enum logic [1:0] {
		BUZZ_IDLE   = 2'd0,
		BUZZ_ACCEPT = 2'd1,
		BUZZ_DENY   = 2'd2
	} buzz_mode_t;

	// Servo sequence in progress.
	typedef enum logic [1:0] {
		SERVO_IDLE = 2'd0,
		SERVO_RISE = 2'd1,
		SERVO_HOLD = 2'd2
	} servo_mode_t;

endpackage

// File: src/dac_if.sv
// Request channel: one control pass.
interface dac_req_if;
	logic                        valid;
	logic                        ready;
	logic [dac_pkg::NOW_W-1:0]   now_ms;
	logic                        motion;
	logic                        card_seen;
	logic [dac_pkg::UID_W-1:0]   card_uid;

	modport source (output valid, now_ms, motion, card_seen, card_uid, input ready);
	modport sink   (input valid, now_ms, motion, card_seen, card_uid, output ready);
endinterface

// Result channel: drive levels after one control pass.
interface dac_res_if;
	logic                        valid;
	logic                        ready;
	logic                        green_led;
	logic                        red_led;
	logic                        buzzer_on;
	logic                        alarm_on;
	logic [dac_pkg::ANGLE_W-1:0] servo_angle;
	logic                        door_cycle;

	modport source (output valid, green_led, red_led, buzzer_on, alarm_on, servo_angle,
		door_cycle, input ready);
	modport sink   (input valid, green_led, red_led, buzzer_on, alarm_on, servo_angle,
		door_cycle, output ready);
endinterface

// File: src/door_access_alarm_controller.sv
// Card-operated door controller with motion alarm.
// The request channel carries one control pass: the millisecond time, the
// motion level and an optional card UID. The result channel returns, for
// every request, the lamp, buzzer and alarm levels, the servo angle and the
// door cycle flag. Both channels use valid/ready; a request is taken at a
// clock edge where valid and ready are both high.
// The result of a request is valid in the cycle after it is taken. One request
// is taken per cycle while the receiver takes results; the state update is a
// single pass of compares and small adds into the state registers, which
// also serve as the result register.
// When the receiver stalls, the result stays held and ready drops until the
// result is taken; a request is still taken in the cycle the result leaves.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while no
// request is in flight; the block does not enforce this. Indexes past the register list are ignored.
// Reset (arst_n low) restores the register defaults, parks the servo at
// 10 degrees, clears all lamps and drives and empties the result slot.
module door_access_alarm_controller #(
	parameter int unsigned TIME_BITS = dac_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dac_pkg::CFG_DAT_W-1:0]   cfg_data,
	dac_req_if.sink                         item,
	dac_res_if.source                       result
);

	// Configuration registers.
	logic [dac_pkg::UID_W-1:0]   accepted_uid_q;
	logic [dac_pkg::ANGLE_W-1:0] open_angle_q;
	logic [dac_pkg::ANGLE_W-1:0] closed_angle_q;
	logic [dac_pkg::BEEPS_W-1:0] beep_count_q;
	logic [dac_pkg::MS16_W-1:0]  open_hold_ms_q;
	logic [dac_pkg::MS16_W-1:0]  alarm_holdoff_ms_q;

	// Controller state.
	logic                        cycle_q, red_mode_q, alarm_act_q;
	dac_pkg::buzz_mode_t         buzz_mode_q;
	dac_pkg::servo_mode_t        servo_mode_q;
	logic [dac_pkg::BEEPS_W-1:0] alarm_beeps_q, accept_beeps_q;
	logic [dac_pkg::ANGLE_W-1:0] angle_q;
	logic [TIME_BITS-1:0]        red_mark_q, alarm_mark_q, buzz_mark_q, servo_mark_q;
	logic [TIME_BITS-1:0]        close_mark_q;
	logic                        green_q, red_q, buzz_q, alarm_q;
	logic                        res_vld_q;

	// Next state.
	logic                        cycle_d, red_mode_d, alarm_act_d;
	dac_pkg::buzz_mode_t         buzz_mode_d;
	dac_pkg::servo_mode_t        servo_mode_d;
	logic [dac_pkg::BEEPS_W-1:0] alarm_beeps_d, accept_beeps_d;
	logic [dac_pkg::ANGLE_W-1:0] angle_d;
	logic [TIME_BITS-1:0]        red_mark_d, alarm_mark_d, buzz_mark_d, servo_mark_d;
	logic [TIME_BITS-1:0]        close_mark_d;
	logic                        green_d, red_d, buzz_d, alarm_d;

	logic                        req_take;
	logic [TIME_BITS-1:0]        now_w;

	// Handshake: take a request whenever the result slot is free or emptying.
	assign item.ready = !res_vld_q || result.ready;
	assign req_take   = item.valid && item.ready;
	assign now_w      = TIME_BITS'(item.now_ms);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_uid_q     <= dac_pkg::ACCEPTED_UID_RST;
			open_angle_q       <= dac_pkg::OPEN_ANGLE_RST;
			closed_angle_q     <= dac_pkg::CLOSED_ANGLE_RST;
			beep_count_q       <= dac_pkg::BEEP_COUNT_RST;
			open_hold_ms_q     <= dac_pkg::OPEN_HOLD_MS_RST;
			alarm_holdoff_ms_q <= dac_pkg::ALARM_HOLDOFF_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dac_pkg::CFG_ACCEPTED_UID:     accepted_uid_q     <= cfg_data;
				dac_pkg::CFG_OPEN_ANGLE:       open_angle_q       <= cfg_data[dac_pkg::ANGLE_W-1:0];
				dac_pkg::CFG_CLOSED_ANGLE:     closed_angle_q     <= cfg_data[dac_pkg::ANGLE_W-1:0];
				dac_pkg::CFG_BEEP_COUNT:       beep_count_q       <= cfg_data[dac_pkg::BEEPS_W-1:0];
				dac_pkg::CFG_OPEN_HOLD_MS:     open_hold_ms_q     <= cfg_data[dac_pkg::MS16_W-1:0];
				dac_pkg::CFG_ALARM_HOLDOFF_MS: alarm_holdoff_ms_q <= cfg_data[dac_pkg::MS16_W-1:0];
				default: ;
			endcase
		end
	end

	// One control pass: denial and alarm handling, card check, hold restart, blink, servo ramp, accept beeps.
	always_comb begin
		logic [TIME_BITS-1:0] dt;
		cycle_d        = cycle_q;
		red_mode_d     = red_mode_q;
		alarm_act_d    = alarm_act_q;
		buzz_mode_d    = buzz_mode_q;
		servo_mode_d   = servo_mode_q;
		alarm_beeps_d  = alarm_beeps_q;
		accept_beeps_d = accept_beeps_q;
		angle_d        = angle_q;
		red_mark_d     = red_mark_q;
		alarm_mark_d   = alarm_mark_q;
		buzz_mark_d    = buzz_mark_q;
		servo_mark_d   = servo_mark_q;
		close_mark_d   = close_mark_q;
		green_d        = green_q;
		red_d          = red_q;
		buzz_d         = buzz_q;
		alarm_d        = alarm_q;
		dt             = '0;

		if (!cycle_d) begin
			// Denial lamp times out after two seconds.
			if (red_mode_d) begin
				if ((now_w - red_mark_d) < TIME_BITS'(dac_pkg::DENY_MS)) begin
					red_d = 1'b1;
				end else begin
					red_d      = 1'b0;
					red_mark_d = now_w;
					red_mode_d = 1'b0;
				end
			end
			// Denial tone times out after two seconds.
			if (buzz_mode_d == dac_pkg::BUZZ_DENY) begin
				if ((now_w - buzz_mark_d) < TIME_BITS'(dac_pkg::DENY_MS)) begin
					buzz_d = 1'b1;
				end else begin
					buzz_d      = 1'b0;
					buzz_mark_d = now_w;
					buzz_mode_d = dac_pkg::BUZZ_IDLE;
				end
			end
			// Motion arms the alarm once the holdoff has passed.
			if (item.motion && !alarm_act_d &&
					(now_w - close_mark_d) >= TIME_BITS'(alarm_holdoff_ms_q)) begin
				alarm_act_d   = 1'b1;
				alarm_beeps_d = '0;
				alarm_mark_d  = now_w;
			end
			// Alarm beep pattern.
			if (alarm_act_d) begin
				dt = now_w - alarm_mark_d;
				if (dt < TIME_BITS'(dac_pkg::ALARM_ON_MS)) begin
					alarm_d = 1'b1;
				end else if (dt < TIME_BITS'(dac_pkg::ALARM_PERIOD_MS)) begin
					alarm_d = 1'b0;
				end else begin
					alarm_beeps_d = alarm_beeps_d + 1'b1;
					alarm_mark_d  = now_w;
				end
				if (alarm_beeps_d >= beep_count_q) begin
					alarm_beeps_d = '0;
					alarm_act_d   = 1'b0;
					close_mark_d  = now_w;
				end
			end
			// Card check.
			if (item.card_seen) begin
				if (item.card_uid == accepted_uid_q) begin
					servo_mode_d = dac_pkg::SERVO_RISE;
					buzz_mode_d  = dac_pkg::BUZZ_ACCEPT;
					cycle_d      = 1'b1;
					red_mode_d   = 1'b0;
					alarm_act_d  = 1'b0;
					buzz_mark_d  = now_w;
					alarm_d      = 1'b0;
					green_d      = 1'b1;
				end else begin
					buzz_mode_d = dac_pkg::BUZZ_DENY;
					red_mode_d  = 1'b1;
					red_mark_d  = now_w;
					buzz_mark_d = now_w;
				end
			end
		end

		// Motion at the open door restarts the hold time.
		if (cycle_d && item.motion && angle_d >= open_angle_q) begin
			servo_mark_d = now_w;
		end

		// Idle blink of the red lamp.
		if (!red_mode_d) begin
			dt = now_w - red_mark_d;
			if (dt < TIME_BITS'(dac_pkg::RED_BLINK_OFF_MS)) begin
				red_d = 1'b0;
			end else if (dt < TIME_BITS'(dac_pkg::RED_BLINK_END_MS)) begin
				red_d = 1'b1;
			end else begin
				red_mark_d = now_w;
			end
		end

		// Servo opening ramp.
		if (servo_mode_d == dac_pkg::SERVO_RISE) begin
			angle_d = (angle_d > dac_pkg::ANGLE_RISE_LIM) ? dac_pkg::ANGLE_MAX
				: angle_d + dac_pkg::ANGLE_STEP;
			if (angle_d >= open_angle_q) begin
				servo_mode_d = dac_pkg::SERVO_HOLD;
				servo_mark_d = now_w;
			end
		end
		// Hold, then closing ramp; reaching the closed angle ends the cycle.
		if (servo_mode_d == dac_pkg::SERVO_HOLD &&
				(now_w - servo_mark_d) >= TIME_BITS'(open_hold_ms_q)) begin
			angle_d = (angle_d < dac_pkg::ANGLE_STEP) ? '0 : angle_d - dac_pkg::ANGLE_STEP;
			if (angle_d <= closed_angle_q) begin
				servo_mode_d = dac_pkg::SERVO_IDLE;
				green_d      = 1'b0;
				cycle_d      = 1'b0;
				close_mark_d = now_w;
			end
		end

		// Accept beep pattern.
		if (buzz_mode_d == dac_pkg::BUZZ_ACCEPT) begin
			dt = now_w - buzz_mark_d;
			if (dt < TIME_BITS'(dac_pkg::BEEP_ON_MS)) begin
				buzz_d = 1'b1;
			end else if (dt < TIME_BITS'(dac_pkg::BEEP_PERIOD_MS)) begin
				buzz_d = 1'b0;
			end else begin
				accept_beeps_d = accept_beeps_d + 1'b1;
				buzz_mark_d    = now_w;
			end
			if (accept_beeps_d >= beep_count_q) begin
				accept_beeps_d = '0;
				buzz_mode_d    = dac_pkg::BUZZ_IDLE;
			end
		end
	end

	// State registers; they also hold the result while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q        <= 1'b0;
			red_mode_q     <= 1'b0;
			alarm_act_q    <= 1'b0;
			buzz_mode_q    <= dac_pkg::BUZZ_IDLE;
			servo_mode_q   <= dac_pkg::SERVO_IDLE;
			alarm_beeps_q  <= '0;
			accept_beeps_q <= '0;
			angle_q        <= dac_pkg::ANGLE_RST;
			red_mark_q     <= '0;
			alarm_mark_q   <= '0;
			buzz_mark_q    <= '0;
			servo_mark_q   <= '0;
			close_mark_q   <= '0 - TIME_BITS'(dac_pkg::CLOSE_MARK_BACK);
			green_q        <= 1'b0;
			red_q          <= 1'b0;
			buzz_q         <= 1'b0;
			alarm_q        <= 1'b0;
		end else if (req_take) begin
			cycle_q        <= cycle_d;
			red_mode_q     <= red_mode_d;
			alarm_act_q    <= alarm_act_d;
			buzz_mode_q    <= buzz_mode_d;
			servo_mode_q   <= servo_mode_d;
			alarm_beeps_q  <= alarm_beeps_d;
			accept_beeps_q <= accept_beeps_d;
			angle_q        <= angle_d;
			red_mark_q     <= red_mark_d;
			alarm_mark_q   <= alarm_mark_d;
			buzz_mark_q    <= buzz_mark_d;
			servo_mark_q   <= servo_mark_d;
			close_mark_q   <= close_mark_d;
			green_q        <= green_d;
			red_q          <= red_d;
			buzz_q         <= buzz_d;
			alarm_q        <= alarm_d;
		end
	end

	// Result slot occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (req_take) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	assign result.valid       = res_vld_q;
	assign result.green_led   = green_q;
	assign result.red_led     = red_q;
	assign result.buzzer_on   = buzz_q;
	assign result.alarm_on    = alarm_q;
	assign result.servo_angle = angle_q;
	assign result.door_cycle  = cycle_q;

	// The green lamp follows the access cycle exactly.
	a_green_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		green_q == cycle_q) else $error("green lamp and door cycle disagree");

	// The servo sequencer runs exactly while a cycle runs.
	a_servo_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(servo_mode_q != dac_pkg::SERVO_IDLE) == cycle_q)
		else $error("servo sequence and door cycle disagree");

	// The intrusion alarm never sounds during an access cycle.
	a_alarm_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q |-> !cycle_q) else $error("alarm on during door cycle");

	// Without a request taken, the servo angle does not move.
	a_angle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!req_take |=> $stable(angle_q)) else $error("servo angle moved without a request");

endmodule
